// File: src/mct_pkg.sv
// Shared types, register codes and helpers for the max-channel tone tint block.
// Depends on nothing; every other file of the block imports it.
package mct_pkg;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int PROD_W  = 2 * CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = PIX_W;
  localparam int MODE_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd3;

  // Blend mode codes; the unused code acts as replace.
  localparam logic [MODE_W-1:0] BLEND_REPLACE = 2'd0;
  localparam logic [MODE_W-1:0] BLEND_ADD     = 2'd1;
  localparam logic [MODE_W-1:0] BLEND_MEAN    = 2'd2;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] TINT_RESET = 24'hFF_FFFF;

  // Register values seen by the datapath.
  typedef struct packed {
    logic              enable;
    logic [PIX_W-1:0]  tint;
    logic [MODE_W-1:0] mode;
    logic              invert;
  } mct_cfg_t;

  // Side information that travels with every pixel through the pipeline.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             bypass;
    logic             last;
  } mct_side_t;

  // Exact floor(p / 255) for any product of two 8-bit values.
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + {{(CH_W+1){1'b0}}, p[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
    return s[PROD_W-1:CH_W];
  endfunction

  // Combines one source channel with its tinted value.
  function automatic logic [CH_W-1:0] combine(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [MODE_W-1:0] mode);
    logic [CH_W:0] s;
    logic [CH_W-1:0] r;
    s = {1'b0, a} + {1'b0, b};
    case (mode)
      BLEND_ADD:  r = s[CH_W] ? CH_MAX : s[CH_W-1:0];
      BLEND_MEAN: r = s[CH_W:1];
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage

// File: src/mct_cfg.sv
// Configuration register file of the max-channel tone tint block.
// Depends on mct_pkg for register codes and the configuration struct.
module mct_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0] cfg_data,
  output mct_pkg::mct_cfg_t            cfg_o
);
  import mct_pkg::*;

  mct_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // Registers update on a write transfer; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b1;
      cfg_r.tint   <= TINT_RESET;
      cfg_r.mode   <= BLEND_REPLACE;
      cfg_r.invert <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE: cfg_r.enable <= cfg_data[0];
        REG_TINT:   cfg_r.tint   <= cfg_data[PIX_W-1:0];
        REG_BLEND:  cfg_r.mode   <= cfg_data[MODE_W-1:0];
        REG_INVERT: cfg_r.invert <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/mct_depth.sv
// First pipeline stage: depth as the largest channel, optionally inverted.
// Depends on mct_pkg for widths and the side-information struct.
module mct_depth (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  logic [mct_pkg::PIX_W-1:0] pixel_i,
  input  logic                    skip_i,
  input  logic                    last_i,
  input  mct_pkg::mct_cfg_t       cfg_i,
  output logic                    valid_o,
  output mct_pkg::mct_side_t      side_o,
  output logic [mct_pkg::CH_W-1:0]  depth_o
);
  import mct_pkg::*;

  logic            valid_r;
  mct_side_t       side_r;
  logic [CH_W-1:0] depth_r;
  logic [CH_W-1:0] red, green, blue, rg_max, max_nxt, depth_nxt;

  // Largest channel, then inversion.
  always_comb begin
    red       = pixel_i[3*CH_W-1:2*CH_W];
    green     = pixel_i[2*CH_W-1:CH_W];
    blue      = pixel_i[CH_W-1:0];
    rg_max    = (green > red) ? green : red;
    max_nxt   = (blue > rg_max) ? blue : rg_max;
    depth_nxt = cfg_i.invert ? (CH_MAX - max_nxt) : max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.pixel  <= pixel_i;
      side_r.bypass <= skip_i | ~cfg_i.enable;
      side_r.last   <= last_i;
      depth_r       <= depth_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign depth_o = depth_r;

endmodule

// File: src/mct_scale.sv
// Second pipeline stage: depth times each tint channel, one 8x8 multiply each.
// Depends on mct_pkg for widths and the side-information struct.
module mct_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  mct_pkg::mct_side_t        side_i,
  input  logic [mct_pkg::CH_W-1:0]    depth_i,
  input  mct_pkg::mct_cfg_t         cfg_i,
  output logic                      valid_o,
  output mct_pkg::mct_side_t        side_o,
  output logic [2:0][mct_pkg::PROD_W-1:0] prod_o
);
  import mct_pkg::*;

  logic                   valid_r;
  mct_side_t              side_r;
  logic [2:0][PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Channel 0 is blue, 2 is red.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= {{CH_W{1'b0}}, depth_i} * {{CH_W{1'b0}}, cfg_i.tint[c*CH_W +: CH_W]};
      end
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign prod_o  = prod_r;

endmodule

// File: src/mct_blend.sv
// Third pipeline stage: divide by 255, blend with the source, output register.
// Depends on mct_pkg for div255, combine and the side-information struct.
module mct_blend (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  mct_pkg::mct_side_t        side_i,
  input  logic [2:0][mct_pkg::PROD_W-1:0] prod_i,
  input  mct_pkg::mct_cfg_t         cfg_i,
  output logic                      valid_o,
  output logic [mct_pkg::PIX_W-1:0]   pixel_o,
  output logic                      last_o
);
  import mct_pkg::*;

  logic             valid_r;
  logic [PIX_W-1:0] pixel_r;
  logic             last_r;
  logic [PIX_W-1:0] blended;

  // Exact quotient per channel, then the selected blend.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blended[c*CH_W +: CH_W] = combine(side_i.pixel[c*CH_W +: CH_W],
                                        div255(prod_i[c]), cfg_i.mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= side_i.bypass ? side_i.pixel : blended;
      last_r  <= side_i.last;
    end
  end

  assign valid_o = valid_r;
  assign pixel_o = pixel_r;
  assign last_o  = last_r;

endmodule

// File: src/max_channel_tone_tint.sv
// Max-channel tone tint: three register stages (depth, multiply, divide and blend).
// One pixel per cycle, except while a finished pixel waits on a stalled output.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset empties the pipeline and restores register defaults:
// enabled, white tint, replace mode, no inversion.
module max_channel_tone_tint (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mct_pkg::PIX_W-1:0]        in_pixel_in,
  input  logic                           in_skip_frame,
  input  logic                           in_end_of_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mct_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mct_pkg::*;

  mct_cfg_t               cfg;
  logic                   en;
  logic                   d_valid, s_valid;
  mct_side_t              d_side, s_side;
  logic [CH_W-1:0]        d_depth;
  logic [2:0][PROD_W-1:0] s_prod;

  // The whole pipeline moves unless a finished pixel waits at the output.
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  mct_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  mct_depth u_depth (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .pixel_i (in_pixel_in),
    .skip_i  (in_skip_frame),
    .last_i  (in_end_of_frame),
    .cfg_i   (cfg),
    .valid_o (d_valid),
    .side_o  (d_side),
    .depth_o (d_depth)
  );

  mct_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .depth_i (d_depth),
    .cfg_i   (cfg),
    .valid_o (s_valid),
    .side_o  (s_side),
    .prod_o  (s_prod)
  );

  mct_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .prod_i  (s_prod),
    .cfg_i   (cfg),
    .valid_o (out_valid),
    .pixel_o (out_pixel_out),
    .last_o  (out_frame_last)
  );

endmodule

// File: tb/tone_tint_checker.sv
// Scoreboard for the max-channel tone tint block: tracks register writes, predicts each pixel.
// Depends on mct_pkg for widths, register indexes and blend codes.
`timescale 1ns / 100ps

module tone_tint_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [mct_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic                         in_skip_frame,
  input  logic                         in_end_of_frame,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [mct_pkg::PIX_W-1:0]      out_pixel_out,
  input  logic                         out_frame_last,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                           pending_cnt,
  output int                           fail_cnt
);
  import mct_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } tinted_pixel_t;

  mct_cfg_t      shadow_cfg;
  tinted_pixel_t tinted_q[$];
  tinted_pixel_t want;

  // Computes the tinted and blended pixel for one source pixel under the given registers.
  function automatic logic [PIX_W-1:0] tint_pixel(input mct_cfg_t c,
                                                  input logic [PIX_W-1:0] px,
                                                  input logic skip);
    int unsigned depth;
    int unsigned src;
    int unsigned toned;
    int unsigned mixed;
    logic [PIX_W-1:0] res;
    if (!c.enable || skip) return px;
    depth = 0;
    for (int k = 0; k < 3; k++) begin
      if (px[CH_W*k +: CH_W] > depth) depth = 32'(px[CH_W*k +: CH_W]);
    end
    if (c.invert) depth = 255 - depth;
    for (int k = 0; k < 3; k++) begin
      src   = 32'(px[CH_W*k +: CH_W]);
      toned = (depth * c.tint[CH_W*k +: CH_W]) / 255;
      case (c.mode)
        BLEND_ADD:  mixed = (src + toned > 255) ? 255 : src + toned;
        BLEND_MEAN: mixed = (src + toned) / 2;
        default:    mixed = toned;
      endcase
      res[CH_W*k +: CH_W] = mixed[CH_W-1:0];
    end
    return res;
  endfunction

  // Register shadow, prediction on each input transfer, comparison on each output transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg  = '{enable: 1'b1, tint: TINT_RESET, mode: BLEND_REPLACE, invert: 1'b0};
      tinted_q.delete();
      pending_cnt = 0;
      fail_cnt    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE: shadow_cfg.enable = cfg_data[0];
          REG_TINT:   shadow_cfg.tint   = cfg_data;
          REG_BLEND:  shadow_cfg.mode   = cfg_data[MODE_W-1:0];
          REG_INVERT: shadow_cfg.invert = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        tinted_q.push_back('{pixel: tint_pixel(shadow_cfg, in_pixel_in, in_skip_frame),
                             last: in_end_of_frame});
      end

      if (out_valid && !out_stall) begin
        if (tinted_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("[%0t] unexpected output transfer: pixel %06h last %0b",
                     $realtime, out_pixel_out, out_frame_last);
        end else begin
          want = tinted_q.pop_front();
          if (want.pixel !== out_pixel_out || want.last !== out_frame_last) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("[%0t] mismatch: pixel %06h (want %06h), last %0b (want %0b)",
                       $realtime, out_pixel_out, want.pixel, out_frame_last, want.last);
          end
        end
      end

      pending_cnt = tinted_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the tone tint testbench: clock, reset, register setup, pixel stimulus and verdict.
// Depends on mct_pkg, the max_channel_tone_tint block and tone_tint_checker.
`timescale 1ns / 100ps

module tb;
  import mct_pkg::*;

  localparam int          LATENCY      = 3;
  localparam int          N_PHASES     = 14;
  localparam int          PHASE_ITEMS  = 140;
  localparam int          N_REGS       = 4;
  localparam int          IDX_TOP      = (1 << CFG_IDX_W) - 1;
  localparam logic [MODE_W-1:0] BLEND_UNUSED = 2'd3;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic [PIX_W-1:0]      in_pixel_in     = '0;
  logic                  in_skip_frame   = 1'b0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_stall       = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_frame_last;
  logic                  cfg_ready;
  int                    pending_cnt;
  int                    fail_cnt;

  max_channel_tone_tint dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_in(in_pixel_in), .in_skip_frame(in_skip_frame),
    .in_end_of_frame(in_end_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_out(out_pixel_out), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tone_tint_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_in(in_pixel_in), .in_skip_frame(in_skip_frame),
    .in_end_of_frame(in_end_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_out(out_pixel_out), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending_cnt(pending_cnt), .fail_cnt(fail_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // One pixel transfer, after an optional gap; leaves valid high on return.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic skip, input logic eof,
                            input bit steady);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_in     <= px;
    in_skip_frame   <= skip;
    in_end_of_frame <= eof;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // One register write transfer; the caller lowers valid after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Holds the sender until every predicted pixel has come out.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Output back-pressure: stall bursts between runs of free flow, some of them long.
  initial begin
    int quiet;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      out_stall <= 1'b1;
      repeat (1 + idle_len()) @(posedge clk);
      out_stall <= 1'b0;
      quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (quiet) @(posedge clk);
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [PIX_W-1:0] dir_px [16] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
      24'h7F7F7F, 24'h010203, 24'hFEFEFE, 24'h00007F, 24'h123456, 24'hABCDEF,
      24'h80FF01, 24'hFF00FF, 24'h000001, 24'h5A5A5A};
    logic              en;
    logic              inv;
    logic [PIX_W-1:0]  tint;
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  px;
    logic [CFG_DATA_W-1:0] word;
    bit                steady;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under the reset register values.
    for (int i = 0; i < 16; i++) begin
      send_pixel(dir_px[i], (i % 5) == 3, (i % 4) == 3, 1'b0);
    end
    in_valid <= 1'b0;

    for (int ph = 1; ph <= N_PHASES; ph++) begin
      // Registers change only once the pipeline has emptied.
      wait_drained();
      repeat (LATENCY + 2) @(posedge clk);

      case (ph)
        1: begin en = 1'b0; tint = PIX_W'($urandom()); mode = BLEND_ADD; inv = 1'b1; end
        2: begin en = 1'b1; tint = 24'h000000; mode = BLEND_REPLACE; inv = 1'b0; end
        3: begin en = 1'b1; tint = 24'hFFFFFF; mode = BLEND_ADD; inv = 1'b1; end
        4: begin en = 1'b1; tint = 24'hFFFFFF; mode = BLEND_MEAN; inv = 1'b0; end
        5: begin en = 1'b1; tint = PIX_W'($urandom()); mode = BLEND_UNUSED; inv = 1'b1; end
        6: begin en = 1'b1; tint = 24'h00FF80; mode = BLEND_MEAN; inv = 1'b1; end
        default: begin
          en  = $urandom_range(0, 5) != 0;
          inv = 1'($urandom_range(0, 1));
          mode = MODE_W'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: tint = 24'hFFFFFF;
            1: tint = 24'h000000;
            default: tint = PIX_W'($urandom());
          endcase
        end
      endcase

      // Unused data bits carry noise; the trailing write to a bad index must be ignored.
      word = CFG_DATA_W'($urandom()); word[0] = en;
      cfg_write(REG_ENABLE, word);
      cfg_write(REG_TINT, tint);
      word = CFG_DATA_W'($urandom()); word[MODE_W-1:0] = mode;
      cfg_write(REG_BLEND, word);
      word = CFG_DATA_W'($urandom()); word[0] = inv;
      cfg_write(REG_INVERT, word);
      cfg_write(CFG_IDX_W'($urandom_range(N_REGS, IDX_TOP)), CFG_DATA_W'($urandom()));
      cfg_valid <= 1'b0;

      steady = (ph % 5) == 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 299) == 0 || (ph == 2 && i == PHASE_ITEMS / 2)) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        // Random pixel, with channels pushed to the extremes now and then.
        px = PIX_W'($urandom());
        if ($urandom_range(0, 3) == 0) begin
          for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
              0: px[CH_W*k +: CH_W] = '0;
              1: px[CH_W*k +: CH_W] = CH_MAX;
              default: ;
            endcase
          end
        end
        send_pixel(px, $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0, steady);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    @(negedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mct_pkg.sv
src/mct_cfg.sv
src/mct_depth.sv
src/mct_scale.sv
src/mct_blend.sv
src/max_channel_tone_tint.sv
tb/tone_tint_checker.sv
tb/tb.sv
